// ===== hdl/pfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, command encoding and status codes of the postfix
// expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

	// Default sizes of the operand stack and the command queue.
	localparam int DEF_STACK_DEPTH = 32;
	localparam int DEF_VALUE_WIDTH = 8;
	localparam int DEF_QUEUE_DEPTH = 2;

	// Field widths on the ports.
	localparam int SYMBOL_W    = 8;
	localparam int OUT_VALUE_W = 8;
	localparam int STATUS_W    = 3;
	localparam int CFG_W       = 6;
	localparam int OUT_DATA_W  = 16;

	// Stack limit after reset.
	localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

	// ASCII codes that the front end recognizes.
	localparam logic [SYMBOL_W-1:0] SYM_ZERO  = 8'h30;
	localparam logic [SYMBOL_W-1:0] SYM_NINE  = 8'h39;
	localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
	localparam logic [SYMBOL_W-1:0] SYM_STAR  = 8'h2A;
	localparam logic [SYMBOL_W-1:0] SYM_SLASH = 8'h2F;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 3'd0,
		STATUS_OVERFLOW = 3'd1,
		STATUS_UNDERFLOW = 3'd2,
		STATUS_DIVZERO  = 3'd3,
		STATUS_EMPTY    = 3'd4
	} status_t;

	// Classified command kinds.
	typedef enum logic [2:0] {
		K_NOP  = 3'd0,
		K_PUSH = 3'd1,
		K_ADD  = 3'd2,
		K_SUB  = 3'd3,
		K_MUL  = 3'd4,
		K_DIV  = 3'd5
	} cmd_kind_t;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  digit;
		logic        last;
	} rpn_cmd_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		S_IDLE    = 3'd0,
		S_EXEC    = 3'd1,
		S_OPERAND = 3'd2,
		S_DIVIDE  = 3'd3,
		S_FINISH  = 3'd4
	} exe_state_t;

endpackage

// ===== hdl/pfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator front end
// Accepts characters, classifies them into stack commands and registers the
// command for the queue. Ignored characters that do not end an expression
// are dropped here.
// ----------------------------------------------------------------------------
module pfe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pfe_pkg::SYMBOL_W-1:0]  s_axis_tdata,   // [7:0] symbol
	input  logic                          s_axis_tlast,   // end_of_expression
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output pfe_pkg::rpn_cmd_t             cmd_data
);
	import pfe_pkg::*;

	logic     valid_s1;
	rpn_cmd_t cmd_s1;
	rpn_cmd_t cmd_class;
	logic     accept;
	logic     keep;

	// Decode the character into a command.
	always_comb begin
		cmd_class.last  = s_axis_tlast;
		cmd_class.digit = 4'(s_axis_tdata - SYM_ZERO);
		if (s_axis_tdata >= SYM_ZERO && s_axis_tdata <= SYM_NINE) begin
			cmd_class.kind = K_PUSH;
		end else if (s_axis_tdata == SYM_PLUS) begin
			cmd_class.kind = K_ADD;
		end else if (s_axis_tdata == SYM_MINUS) begin
			cmd_class.kind = K_SUB;
		end else if (s_axis_tdata == SYM_STAR) begin
			cmd_class.kind = K_MUL;
		end else if (s_axis_tdata == SYM_SLASH) begin
			cmd_class.kind = K_DIV;
		end else begin
			cmd_class.kind = K_NOP;
		end
	end

	// The stage takes a new item when it is empty or its content leaves this cycle.
	assign s_axis_tready = !valid_s1 || cmd_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign keep          = (cmd_class.kind != K_NOP) || cmd_class.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_class;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd_data  = cmd_s1;

endmodule

// ===== hdl/pfe_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator command queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module pfe_fifo #(
	parameter int DEPTH = pfe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pfe_pkg::rpn_cmd_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pfe_pkg::rpn_cmd_t out_data
);
	import pfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rpn_cmd_t         slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = fill_q != CNT_W'(DEPTH);
	assign out_valid = fill_q != '0;
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ===== hdl/pfe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed restoring divider, one quotient bit per cycle, quotient truncated
// toward zero and wrapped to the operand width.
// ----------------------------------------------------------------------------
module pfe_div #(
	parameter int VALUE_WIDTH = pfe_pkg::DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient
);
	import pfe_pkg::*;

	localparam int STEP_W = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_W-1:0]      step_q;
	logic [VALUE_WIDTH:0]   rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] den_q;
	logic                   neg_q;
	logic [VALUE_WIDTH:0]   rem_shift;
	logic                   fits;
	logic                   last_step;

	assign rem_shift = {rem_q[VALUE_WIDTH-1:0], quo_q[VALUE_WIDTH-1]};
	assign fits      = rem_shift >= {1'b0, den_q};
	assign last_step = step_q == STEP_W'(VALUE_WIDTH - 1);

	// Sequencing of the shift-subtract steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand magnitudes, partial remainder and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[VALUE_WIDTH-1] ? -dividend : dividend;
			den_q <= divisor[VALUE_WIDTH-1] ? -divisor : divisor;
			rem_q <= '0;
			neg_q <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
		end else if (busy_q) begin
			rem_q <= fits ? rem_shift - {1'b0, den_q} : rem_shift;
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule

// ===== hdl/pfe_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator back end
// Runs the classified commands against the operand stack. The top of stack
// lives in a register, the entries below it in a one-write one-read memory.
// Emits value and status on the last item of each expression.
// ----------------------------------------------------------------------------
module pfe_exec #(
	parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = pfe_pkg::DEF_VALUE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pfe_pkg::CFG_W-1:0]      stack_limit,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  pfe_pkg::rpn_cmd_t              cmd_data,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [pfe_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [7:0] value, [10:8] status
);
	import pfe_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	exe_state_t             state_q;
	exe_state_t             state_d;
	rpn_cmd_t               cmd_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic                   count_we;
	status_t                err_q;
	status_t                err_new;
	logic                   err_set;
	logic [VALUE_WIDTH-1:0] tos_q;
	logic [VALUE_WIDTH-1:0] tos_d;
	logic                   tos_we;
	logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_raddr;
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic                   out_free;
	logic                   out_load;
	logic                   out_valid_q;
	logic [OUT_VALUE_W-1:0] out_value_q;
	status_t                out_status_q;
	logic [LIM_W-1:0]       lim_raw;
	logic [LIM_W-1:0]       lim_eff;
	logic [LIM_W-1:0]       count_ext;
	logic                   two_or_more;

	// Effective limit: zero acts as one, anything above the depth as the depth.
	assign lim_raw = LIM_W'(stack_limit);
	always_comb begin
		if (lim_raw == '0) begin
			lim_eff = LIM_W'(1);
		end else if (lim_raw > LIM_W'(STACK_DEPTH)) begin
			lim_eff = LIM_W'(STACK_DEPTH);
		end else begin
			lim_eff = lim_raw;
		end
	end

	assign count_ext   = LIM_W'(count_q);
	assign two_or_more = count_q >= CNT_W'(2);
	assign out_free    = !out_valid_q || m_axis_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd_q.kind == K_ADD || cmd_q.kind == K_SUB ||
				    cmd_q.kind == K_MUL || cmd_q.kind == K_DIV) begin
					state_d = two_or_more ? S_OPERAND : S_FINISH;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_OPERAND: begin
				state_d = (cmd_q.kind == K_DIV && tos_q != '0) ? S_DIVIDE : S_FINISH;
			end
			S_DIVIDE: begin
				if (div_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!cmd_q.last || out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath controls per state.
	always_comb begin
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(count_q - 1'b1);
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(count_q - CNT_W'(2));
		div_start = 1'b0;
		tos_we    = 1'b0;
		tos_d     = tos_q;
		count_we  = 1'b0;
		count_d   = count_q;
		err_set   = 1'b0;
		err_new   = STATUS_OK;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
			end
			S_EXEC: begin
				unique case (cmd_q.kind)
					K_PUSH: begin
						if (count_ext >= lim_eff) begin
							err_set = 1'b1;
							err_new = STATUS_OVERFLOW;
						end else begin
							// Spill the old top below the new one.
							mem_we   = count_q != '0;
							tos_we   = 1'b1;
							tos_d    = VALUE_WIDTH'(cmd_q.digit);
							count_we = 1'b1;
							count_d  = count_q + 1'b1;
						end
					end
					K_ADD, K_SUB, K_MUL, K_DIV: begin
						if (two_or_more) begin
							mem_re = 1'b1;
						end else begin
							err_set = 1'b1;
							err_new = STATUS_UNDERFLOW;
						end
					end
					K_NOP: begin
					end
					default: begin
					end
				endcase
			end
			S_OPERAND: begin
				// Left operand from memory, right operand is the top register.
				count_d = count_q - 1'b1;
				unique case (cmd_q.kind)
					K_ADD: begin
						tos_we   = 1'b1;
						tos_d    = rd_data_q + tos_q;
						count_we = 1'b1;
					end
					K_SUB: begin
						tos_we   = 1'b1;
						tos_d    = rd_data_q - tos_q;
						count_we = 1'b1;
					end
					K_MUL: begin
						tos_we   = 1'b1;
						tos_d    = rd_data_q * tos_q;
						count_we = 1'b1;
					end
					K_DIV: begin
						if (tos_q == '0) begin
							err_set  = 1'b1;
							err_new  = STATUS_DIVZERO;
							tos_we   = 1'b1;
							tos_d    = '0;
							count_we = 1'b1;
						end else begin
							div_start = 1'b1;
						end
					end
					K_NOP, K_PUSH: begin
					end
					default: begin
					end
				endcase
			end
			S_DIVIDE: begin
				if (div_done) begin
					tos_we   = 1'b1;
					tos_d    = div_quot;
					count_we = 1'b1;
					count_d  = count_q - 1'b1;
				end
			end
			S_FINISH: begin
				out_load = cmd_q.last && out_free;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, stack count and kept error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q   <= STATUS_OK;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				count_q <= '0;
				err_q   <= STATUS_OK;
			end else begin
				if (count_we) count_q <= count_d;
				if (err_set && err_q == STATUS_OK) err_q <= err_new;
			end
		end
	end

	// Command and top-of-stack registers.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd_data;
		end
		if (tos_we) begin
			tos_q <= tos_d;
		end
	end

	// Stack memory below the top entry.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= tos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_q <= stack_mem[mem_raddr];
		end
	end

	pfe_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data_q),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= (count_q != '0) ? OUT_VALUE_W'(tos_q) : '0;
			if (err_q != STATUS_OK) begin
				out_status_q <= err_q;
			end else if (count_q == '0) begin
				out_status_q <= STATUS_EMPTY;
			end else begin
				out_status_q <= STATUS_OK;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - OUT_VALUE_W - STATUS_W)'(0), out_status_q, out_value_q};

	// The stack count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	// A result is loaded only when the result register can take it.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten");

	// Emitting a result clears the stack and the kept error.
	a_out_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q == '0 && err_q == STATUS_OK))
		else $error("stack not cleared after result");

	// The divider is started only for a division with a nonzero divisor.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (cmd_q.kind == K_DIV && tos_q != '0 && state_q == S_OPERAND))
		else $error("divider started wrongly");

	// The divider finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVIDE)
		else $error("divider done outside divide state");

endmodule

// ===== hdl/postfix_expression_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates postfix expressions given one ASCII character per item and
// returns the top of stack with a status on the last character.
// ----------------------------------------------------------------------------
// A character item passes a one-stage front end that classifies it and a
// short command queue, then the back-end sequencer runs it against the
// operand stack. The input side keeps taking items while the back end works
// or a result waits, until the front stage and the queue are full. In the
// back end every item passes the idle, execute and finish states; '+', '-',
// '*' and '/' with two or more operands also pass the operand state, and a
// '/' with a nonzero divisor then waits in the divide state for the
// one-bit-per-cycle divider. A last character also waits while the result
// register still holds an item. The top of stack sits in a register and the
// entries below it in a memory with one write and one registered read port.
// Digits push 0 to 9, operators wrap to VALUE_WIDTH bits, division truncates
// toward zero, and the first error of an expression is kept. The stack_limit
// register, written through cfg_wr_en and cfg_wr_data, caps the entries in
// use; the user is to write it only while the block is idle, which the block
// itself does not enforce. Zero acts as one and values above STACK_DEPTH act as STACK_DEPTH.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = pfe_pkg::DEF_VALUE_WIDTH,
	parameter int QUEUE_DEPTH = pfe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [pfe_pkg::SYMBOL_W-1:0]   s_axis_tdata,   // [7:0] symbol
	input  logic                           s_axis_tlast,   // end_of_expression
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [pfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] value, [10:8] status
	input  logic                           cfg_wr_en,
	input  logic [pfe_pkg::CFG_W-1:0]      cfg_wr_data     // [5:0] stack_limit
);
	import pfe_pkg::*;

	logic [CFG_W-1:0] limit_q;
	logic             fe_valid;
	logic             fe_ready;
	rpn_cmd_t         fe_cmd;
	logic             be_valid;
	logic             be_ready;
	rpn_cmd_t         be_cmd;

	// Stack limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	pfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cmd_valid     (fe_valid),
		.cmd_ready     (fe_ready),
		.cmd_data      (fe_cmd)
	);

	pfe_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_data   (fe_cmd),
		.out_valid (be_valid),
		.out_ready (be_ready),
		.out_data  (be_cmd)
	);

	pfe_exec #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.stack_limit   (limit_q),
		.cmd_valid     (be_valid),
		.cmd_ready     (be_ready),
		.cmd_data      (be_cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== tb/pfe_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator result checker
// Watches the character, result and stack limit channels of the evaluator,
// evaluates every accepted character on its own copy of the operand stack
// and compares each accepted result, field by field, with the oldest one
// it has worked out.
// ----------------------------------------------------------------------------
module pfe_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [pfe_pkg::SYMBOL_W-1:0]   s_axis_tdata,   // [7:0] symbol
	input  logic                           s_axis_tlast,   // end_of_expression
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [pfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] value, [10:8] status
	input  logic                           cfg_wr_en,
	input  logic [pfe_pkg::CFG_W-1:0]      cfg_wr_data,    // [5:0] stack_limit
	output int                             fail_count,
	output int                             pending,
	output int                             results_seen
);
	import pfe_pkg::*;

	typedef struct packed {
		logic [OUT_VALUE_W-1:0] value;
		status_t                status;
	} pfe_result_t;

	// Shadow copy of the operand stack, the kept error and the limit.
	logic [OUT_VALUE_W-1:0] stack_mem [0:DEF_STACK_DEPTH-1];
	int unsigned            depth;
	status_t                first_err;
	logic [CFG_W-1:0]       limit_reg;
	pfe_result_t            predicted_results [$];

	// A limit of zero acts as one, anything above the depth as the depth.
	function automatic int unsigned usable_entries();
		int unsigned lim;
		lim = limit_reg;
		if (lim < 1)
			lim = 1;
		if (lim > DEF_STACK_DEPTH)
			lim = DEF_STACK_DEPTH;
		return lim;
	endfunction

	// Only the first error of an expression is kept.
	task automatic note_error(input status_t code);
		if (first_err == STATUS_OK)
			first_err = code;
	endtask

	// A push onto a full stack is dropped and flagged.
	task automatic push_entry(input logic [OUT_VALUE_W-1:0] v);
		if (depth >= usable_entries()) begin
			note_error(STATUS_OVERFLOW);
		end else begin
			stack_mem[depth] = v;
			depth++;
		end
	endtask

	// Applies one character and, on the last one, records the result it causes.
	task automatic evaluate_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
		int          lhs;
		int          rhs;
		int          res;
		pfe_result_t r;
		if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
			push_entry(sym - SYM_ZERO);
		end else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_STAR ||
				sym == SYM_SLASH) begin
			if (depth < 2) begin
				note_error(STATUS_UNDERFLOW);
			end else begin
				rhs = signed'(stack_mem[depth-1]);
				lhs = signed'(stack_mem[depth-2]);
				depth -= 2;
				if (sym == SYM_PLUS) begin
					res = lhs + rhs;
				end else if (sym == SYM_MINUS) begin
					res = lhs - rhs;
				end else if (sym == SYM_STAR) begin
					res = lhs * rhs;
				end else if (rhs == 0) begin
					note_error(STATUS_DIVZERO);
					res = 0;
				end else begin
					// Integer division truncates toward zero; -128 / -1 wraps below.
					res = lhs / rhs;
				end
				push_entry(res[OUT_VALUE_W-1:0]);
			end
		end
		if (last) begin
			r.value = (depth > 0) ? stack_mem[depth-1] : '0;
			if (first_err != STATUS_OK)
				r.status = first_err;
			else if (depth == 0)
				r.status = STATUS_EMPTY;
			else
				r.status = STATUS_OK;
			predicted_results.push_back(r);
			depth = 0;
			first_err = STATUS_OK;
		end
	endtask

	// Compares one accepted result with the oldest prediction.
	task automatic compare_result(input logic [OUT_DATA_W-1:0] data);
		pfe_result_t want;
		results_seen++;
		if (predicted_results.size() == 0) begin
			$error("result item with no prediction waiting: tdata 0x%04h", data);
			fail_count++;
		end else begin
			want = predicted_results.pop_front();
			if (data[7:0] !== want.value) begin
				$error("value: expected %0d, actual %0d", $signed(want.value),
					$signed(data[7:0]));
				fail_count++;
			end
			if (data[10:8] !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, data[10:8]);
				fail_count++;
			end
			if (data[OUT_DATA_W-1:11] !== '0) begin
				$error("padding: expected 0, actual 0x%0h", data[OUT_DATA_W-1:11]);
				fail_count++;
			end
		end
	endtask

	// Result first: it always belongs to a character taken in an earlier cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth = 0;
			first_err = STATUS_OK;
			limit_reg = LIMIT_RESET;
			predicted_results.delete();
			fail_count = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				compare_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				evaluate_symbol(s_axis_tdata, s_axis_tlast);
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			pending = predicted_results.size();
		end
	end

endmodule

// ===== tb/tb_postfix_expression_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Drives directed and random postfix expressions through the evaluator under
// several stack limits, with random gaps on the character side and random
// back-pressure on the result side; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
	import pfe_pkg::*;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_COUNT    = 8;
	localparam int PHASE_ITEMS    = 80;
	localparam int QUIET_PHASE    = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [SYMBOL_W-1:0]   s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_wr_en;
	logic [CFG_W-1:0]      cfg_wr_data;

	int   fail_count;
	int   pending;
	int   results_seen;
	int   cycle_count;
	int   items_sent;
	int   counted_items;
	int   limit_writes;
	logic quiet;

	postfix_expression_evaluator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	pfe_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen)
	);

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Random back-pressure on the result side, none in the quiet stretch.
	always @(negedge clk)
		m_axis_tready <= quiet || ($urandom_range(0, 99) >= 32);

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic is_meaningful(input logic [SYMBOL_W-1:0] sym);
		return (sym >= SYM_ZERO && sym <= SYM_NINE) || sym == SYM_PLUS ||
			sym == SYM_MINUS || sym == SYM_STAR || sym == SYM_SLASH;
	endfunction

	function automatic logic [SYMBOL_W-1:0] random_digit();
		return SYM_ZERO + SYMBOL_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [SYMBOL_W-1:0] random_operator();
		case ($urandom_range(0, 3))
			0: return SYM_PLUS;
			1: return SYM_MINUS;
			2: return SYM_STAR;
			default: return SYM_SLASH;
		endcase
	endfunction

	// Presents one character item after an optional gap and waits until taken.
	// Returns at the falling edge after acceptance with tvalid still high.
	task automatic send_item(input logic [SYMBOL_W-1:0] sym, input logic last);
		while (!quiet && $urandom_range(0, 99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sym;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (is_meaningful(sym) || last)
			counted_items++;
	endtask

	// Sends a whole expression, the last character marked as the end.
	task automatic send_expr(input string text);
		for (int i = 0; i < text.len(); i++)
			send_item(text[i], i == text.len() - 1);
	endtask

	// Sends a queue of characters as one expression.
	task automatic send_queue(ref logic [SYMBOL_W-1:0] syms [$]);
		foreach (syms[i])
			send_item(syms[i], i == syms.size() - 1);
	endtask

	// Lets every predicted result come out, then lets the design settle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] lim);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		limit_writes++;
	endtask

	// Builds one random expression: mostly well formed, some broken or noise.
	task automatic send_random_expr();
		logic [SYMBOL_W-1:0] syms [$];
		int                  mode;
		int                  want;
		int                  pushed;
		int                  live;
		logic                deep;
		mode = $urandom_range(0, 99);
		if (mode < 70) begin
			// Well formed; now and then a deep one that can run past the limit.
			deep = ($urandom_range(0, 19) == 0);
			want = deep ? $urandom_range(28, 36) : $urandom_range(1, 6);
			pushed = 0;
			live = 0;
			while (pushed < want || live > 1) begin
				if (pushed < want && (live < 2 || deep || $urandom_range(0, 1))) begin
					syms.push_back(random_digit());
					pushed++;
					live++;
				end else begin
					syms.push_back(random_operator());
					live--;
				end
				if ($urandom_range(0, 99) < 5)
					syms.push_back(SYMBOL_W'($urandom_range(0, 255)));
			end
		end else if (mode < 88) begin
			// Broken sequence of random tokens.
			want = $urandom_range(1, 8);
			for (int i = 0; i < want; i++) begin
				case ($urandom_range(0, 2))
					0: syms.push_back(random_digit());
					1: syms.push_back(random_operator());
					default: syms.push_back(SYMBOL_W'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			// Pure noise bytes.
			want = $urandom_range(1, 4);
			for (int i = 0; i < want; i++)
				syms.push_back(SYMBOL_W'($urandom_range(0, 255)));
		end
		send_queue(syms);
	endtask

	initial begin
		logic [CFG_W-1:0] phase_limit [PHASE_COUNT];
		int               target;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		quiet = 1'b0;
		items_sent = 0;
		counted_items = 0;
		limit_writes = 0;
		phase_limit = '{6'd2, 6'd63, 6'd0, 6'd5, 6'd32, 6'd33, 6'd1,
			CFG_W'($urandom_range(0, 63))};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset limit.
		send_expr("34+");
		send_expr("09-9*");
		send_expr("80/");                // divide by zero
		send_expr("+");                  // underflow on an empty stack
		send_expr("a");                  // ignored character, empty stack
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_expr("08-8*2*01-/");        // most negative value over -1
		settle();

		// Push onto a full stack with a limit of one.
		write_limit(6'd1);
		send_expr("12");
		settle();

		// Random phases, each under its own stack limit.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_limit(phase_limit[p]);
			quiet = (p == QUIET_PHASE);
			target = counted_items + PHASE_ITEMS;
			while (counted_items < target)
				send_random_expr();
			settle();
		end
		quiet = 1'b0;

		// Drain whatever is left.
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d characters (%0d digits, operators or ends) under %0d limit writes.",
			items_sent, counted_items, limit_writes);
		$display("Checked %0d results in %0d cycles.", results_seen, cycle_count);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
